@@ rtl/cck_pkg.sv @@
`default_nettype none

package cck_pkg;

  // block function configuration
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned ROUND_CNT     = 2 * DOUBLE_ROUNDS;
  localparam int unsigned ROUND_W       = (ROUND_CNT > 1) ? $clog2(ROUND_CNT) : 1;

  // request queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] blk_t;
  typedef logic [3:0][31:0]  quad_t;

  localparam quad_t SIGMA = {32'h638e2b99, 32'h1467c0fb, 32'h2086ca69, 32'hfa835867};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY01   = 3'd0,
    REG_KEY23   = 3'd1,
    REG_KEY45   = 3'd2,
    REG_KEY67   = 3'd3,
    REG_NONCE01 = 3'd4,
    REG_NONCE2  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } cfg_t;

  // one classified request in the queue
  typedef struct packed {
    word_t       plain;
    logic [3:0]  pos;
    word_t       ctr;
    logic        new_block;
  } q_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] cnt;
  } q_stat_t;

  typedef struct packed {
    logic  start;
    word_t ctr;
  } blk_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } blk_stat_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic quad_t quarter_round(input quad_t q);
    word_t a, b, c, d;
    a = q[0]; b = q[1]; c = q[2]; d = q[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {d, c, b, a};
  endfunction

  // one column round (diag = 0) or one diagonal round (diag = 1)
  function automatic blk_t chacha_round(input blk_t s, input logic diag);
    blk_t       r;
    quad_t      q;
    logic [1:0] col;
    logic [1:0] o1, o2, o3;
    logic [3:0] ia, ib, ic, id;
    r  = s;
    o1 = diag ? 2'd1 : 2'd0;
    o2 = diag ? 2'd2 : 2'd0;
    o3 = diag ? 2'd3 : 2'd0;
    for (int k = 0; k < 4; k++) begin
      col = 2'(k);
      ia  = {2'b00, col};
      ib  = {2'b01, 2'(col + o1)};
      ic  = {2'b10, 2'(col + o2)};
      id  = {2'b11, 2'(col + o3)};
      q   = quarter_round({s[id], s[ic], s[ib], s[ia]});
      r[ia] = q[0];
      r[ib] = q[1];
      r[ic] = q[2];
      r[id] = q[3];
    end
    return r;
  endfunction

  function automatic blk_t init_state(input cfg_t cfg, input word_t ctr);
    blk_t s;
    for (int i = 0; i < 4; i++) s[i] = SIGMA[i];
    for (int i = 0; i < 8; i++) s[4 + i] = cfg.key[i];
    s[12] = ctr;
    for (int i = 0; i < 3; i++) s[13 + i] = cfg.nonce[i];
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cck_front.sv @@
`default_nettype none

module cck_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [31:0]       plain_word_i,
  input  wire logic              message_end_i,
  input  wire cck_pkg::q_stat_t  q_stat_i,
  output logic                   push_o,
  output cck_pkg::q_entry_t      push_entry_o
);
  import cck_pkg::*;

  logic [3:0] pos_q, pos_d;
  word_t      ctr_q, ctr_d;

  // accept whenever the queue has room
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // classify the request: position, counter and whether a block starts here
  always_comb begin
    push_entry_o.plain     = plain_word_i;
    push_entry_o.pos       = pos_q;
    push_entry_o.ctr       = ctr_q;
    push_entry_o.new_block = (pos_q == 4'd0);
  end

  // next position and block counter
  always_comb begin
    pos_d = pos_q + 4'd1;
    ctr_d = (pos_q == 4'hf) ? ctr_q + 32'd1 : ctr_q;
    if (message_end_i) begin
      pos_d = 4'd0;
      ctr_d = 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      ctr_q <= 32'd1;
    end else if (push_o) begin
      pos_q <= pos_d;
      ctr_q <= ctr_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cck_queue.sv @@
`default_nettype none

module cck_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cck_pkg::q_entry_t  push_entry_i,
  input  wire logic               pop_i,
  output cck_pkg::q_entry_t       head_o,
  output cck_pkg::q_stat_t        stat_o
);
  import cck_pkg::*;

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.cnt   = cnt_q;
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cck_block.sv @@
`default_nettype none

module cck_block (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cck_pkg::cfg_t      cfg_i,
  input  wire cck_pkg::blk_ctrl_t ctrl_i,
  output cck_pkg::blk_stat_t      stat_o,
  output cck_pkg::blk_t           ks_o
);
  import cck_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } state_e;

  state_e             state_q;
  logic [ROUND_W-1:0] round_q;
  word_t              ctr_q;
  blk_t               st_q;
  blk_t               ks_q;
  blk_t               init_w;

  assign init_w      = init_state(cfg_i, ctr_q);
  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_FINAL);
  assign ks_o        = ks_q;

  // load, one round per cycle, then feed-forward add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl_i.start) begin
            ctr_q   <= ctrl_i.ctr;
            st_q    <= init_state(cfg_i, ctrl_i.ctr);
            round_q <= '0;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          st_q    <= chacha_round(st_q, round_q[0]);
          round_q <= round_q + 1'b1;
          if (round_q == ROUND_W'(ROUND_CNT - 1)) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 16; i++) ks_q[i] <= init_w[i] + st_q[i];
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/cck_back.sv @@
`default_nettype none

module cck_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cck_pkg::cfg_t      cfg_i,
  input  wire cck_pkg::q_entry_t  head_i,
  input  wire cck_pkg::q_stat_t   q_stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [31:0]             cipher_word_o
);
  import cck_pkg::*;

  blk_ctrl_t blk_ctrl;
  blk_stat_t blk_stat;
  blk_t      ks;
  logic      blk_done_q;
  logic      head_valid;
  logic      slot_free;
  logic      out_valid_q;
  word_t     cipher_q;

  cck_block u_block (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .ctrl_i (blk_ctrl),
    .stat_o (blk_stat),
    .ks_o   (ks)
  );

  // launch the block unit when the head request opens a new block
  assign head_valid     = !q_stat_i.empty;
  assign slot_free      = !out_valid_q || !out_stall_i;
  assign blk_ctrl.start = head_valid && head_i.new_block && !blk_done_q && !blk_stat.busy;
  assign blk_ctrl.ctr   = head_i.ctr;

  // retire the head once its keystream word is ready and the output slot is free
  assign pop_o = head_valid && (!head_i.new_block || blk_done_q) && slot_free;

  assign out_valid_o   = out_valid_q;
  assign cipher_word_o = cipher_q;

  // block-ready flag for the request that opened it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_done_q <= 1'b0;
    end else if (blk_stat.done) begin
      blk_done_q <= 1'b1;
    end else if (pop_o && head_i.new_block) begin
      blk_done_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cipher_q <= head_i.plain ^ ks[head_i.pos];
    end
  end

endmodule

`default_nettype wire

@@ rtl/chacha_keystream_cipher.sv @@
// channel   direction  handshake                   payload
// cfg       in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i / in_stall_o     plain_word_i, message_end_i
// out       out        out_valid_o / out_stall_i   cipher_word_o
//
// a request that opens a keystream block waits in the block unit (load, one round
// per cycle, feed-forward add); the other fifteen words of the block leave one per
// cycle while out_stall_i is low
// reset: block counter 1, word position 0, queue and output empty; no clearing pass
// in_stall_o rises only when the four-entry request queue is full
// out_stall_i holds the output register and the queue keeps filling behind it
`default_nettype none

module chacha_keystream_cipher (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cck_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cck_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [31:0]                     plain_word_i,
  input  wire logic                            message_end_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [31:0]                          cipher_word_o
);
  import cck_pkg::*;

  cfg_t     cfg_q;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  q_entry_t head;
  q_stat_t  q_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY01:   cfg_q.key[1:0]   <= cfg_wdata_i;
        REG_KEY23:   cfg_q.key[3:2]   <= cfg_wdata_i;
        REG_KEY45:   cfg_q.key[5:4]   <= cfg_wdata_i;
        REG_KEY67:   cfg_q.key[7:6]   <= cfg_wdata_i;
        REG_NONCE01: cfg_q.nonce[1:0] <= cfg_wdata_i;
        REG_NONCE2:  cfg_q.nonce[2]   <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  cck_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .plain_word_i  (plain_word_i),
    .message_end_i (message_end_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  cck_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  cck_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cipher_word_o (cipher_word_o)
  );

  // queue never overfills
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.cnt <= QCNT_W'(QDEPTH))
    else $error("request queue count out of range");

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty request queue");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !pop)
    else $error("pending result overwritten");

  // a push without a pop grows the queue by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (q_stat.cnt == $past(q_stat.cnt) + 1'b1))
    else $error("request queue count step wrong");

endmodule

`default_nettype wire

@@ bench/chacha_keystream_cipher_test.sv @@
`timescale 1ns / 100ps

module chacha_keystream_cipher_test;
  import cck_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_WORDS    = 150;

  // register indexes past the end of the map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  // the four block constants, word 0 in the low slot
  localparam logic [3:0][31:0] BLOCK_CONSTS =
    {32'h638e2b99, 32'h1467c0fb, 32'h2086ca69, 32'hfa835867};

  typedef struct packed {
    word_t plain;
    logic  last;
  } plain_req_t;

  // dut ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [31:0]           plain_word_i  = '0;
  logic                  message_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [31:0]           cipher_word_o;

  // predictor state
  word_t      key_w [8]   = '{default: '0};
  word_t      nonce_w [3] = '{default: '0};
  word_t      block_ctr   = 32'd1;
  logic [3:0] word_pos    = 4'd0;
  blk_t       ks_blk      = '0;

  // request and expected cipher word stores
  plain_req_t request_q [$];
  word_t      cipher_expect_q [$];
  plain_req_t sent_req;
  word_t      cipher_due;

  // handshake bookkeeping
  bit          req_fired    = 1'b0;
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  // run statistics
  int unsigned words_in       = 0;
  int unsigned words_out      = 0;
  int unsigned message_count  = 0;
  int unsigned settings_count = 0;
  int unsigned full_cycles    = 0;
  int unsigned mismatches     = 0;

  chacha_keystream_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .plain_word_i  (plain_word_i),
    .message_end_i (message_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cipher_word_o (cipher_word_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // rotate left, n in 1..31
  function automatic word_t rol32(input word_t v, input int unsigned n);
    logic [63:0] twice;
    twice = {v, v};
    return twice[63 - n -: 32];
  endfunction

  function automatic blk_t quarter_mix(input blk_t s, input int a, b, c, d);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
    return s;
  endfunction

  // one keystream block from the current key and nonce
  function automatic blk_t keystream_block(input word_t ctr);
    blk_t seed;
    blk_t w;
    int   i;
    int   r;
    seed[3:0] = BLOCK_CONSTS;
    for (i = 0; i < 8; i++) seed[4 + i] = key_w[i];
    seed[12] = ctr;
    for (i = 0; i < 3; i++) seed[13 + i] = nonce_w[i];
    w = seed;
    for (r = 0; r < DOUBLE_ROUNDS; r++) begin
      w = quarter_mix(w, 0, 4, 8, 12);
      w = quarter_mix(w, 1, 5, 9, 13);
      w = quarter_mix(w, 2, 6, 10, 14);
      w = quarter_mix(w, 3, 7, 11, 15);
      w = quarter_mix(w, 0, 5, 10, 15);
      w = quarter_mix(w, 1, 6, 11, 12);
      w = quarter_mix(w, 2, 7, 8, 13);
      w = quarter_mix(w, 3, 4, 9, 14);
    end
    for (i = 0; i < 16; i++) w[i] = w[i] + seed[i];
    return w;
  endfunction

  // encrypt one word and advance position and counter
  function automatic word_t next_cipher_word(input word_t plain, input logic last);
    word_t ks;
    if (word_pos == 4'd0) ks_blk = keystream_block(block_ctr);
    ks = ks_blk[word_pos];
    word_pos = word_pos + 4'd1;
    if (word_pos == 4'd0) block_ctr = block_ctr + 32'd1;
    if (last) begin
      block_ctr = 32'd1;
      word_pos  = 4'd0;
    end
    return plain ^ ks;
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_KEY01:   {key_w[1], key_w[0]}     = data;
      REG_KEY23:   {key_w[3], key_w[2]}     = data;
      REG_KEY45:   {key_w[5], key_w[4]}     = data;
      REG_KEY67:   {key_w[7], key_w[6]}     = data;
      REG_NONCE01: {nonce_w[1], nonce_w[0]} = data;
      REG_NONCE2:  nonce_w[2]               = data[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // key and nonce setting for the next phase
  task automatic apply_setting(input int unsigned kind);
    int idx;
    case (kind)
      0: for (idx = REG_KEY01; idx <= REG_NONCE2; idx++)
           write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
      1: for (idx = REG_KEY01; idx <= REG_NONCE2; idx++) write_reg(CFG_IDX_W'(idx), '1);
      2: for (idx = REG_KEY01; idx <= REG_NONCE2; idx++) write_reg(CFG_IDX_W'(idx), '0);
      default: begin
        // partial update plus writes to unmapped indexes
        write_reg(REG_SPARE6, {$urandom, $urandom});
        write_reg(CFG_IDX_W'($urandom_range(REG_KEY01, REG_NONCE2)), {$urandom, $urandom});
        write_reg(REG_SPARE7, {$urandom, $urandom});
        write_reg(REG_NONCE2, {$urandom, $urandom});
      end
    endcase
    settings_count++;
  endtask

  task automatic push_word(input word_t plain, input logic last);
    plain_req_t req;
    req.plain = plain;
    req.last  = last;
    request_q.push_back(req);
    if (last) message_count++;
  endtask

  // random messages, optionally leaving the final one open
  task automatic queue_messages(input int unsigned count, input bit leave_open);
    int unsigned left;
    int unsigned len;
    int unsigned k;
    word_t       w;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0, 1:    len = 16 * $urandom_range(1, 2);
        2, 3:    len = $urandom_range(1, 3);
        default: len = $urandom_range(1, 40);
      endcase
      if (len > left) len = left;
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0:       w = '0;
          1:       w = '1;
          default: w = $urandom;
        endcase
        push_word(w, (k == len - 1) && !(leave_open && left == len));
      end
      left -= len;
    end
  endtask

  // wait until every request is through and the block has settled
  task automatic drain();
    while (request_q.size() != 0 || cipher_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_fired) begin
      req_fired = 1'b0;
      if (send_gap == 0 && !calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_valid_i    <= 1'b1;
        plain_word_i  <= request_q[0].plain;
        message_end_i <= request_q[0].last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: predict on accepted requests, compare accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) full_cycles++;
      if (in_valid_i && !in_stall_o) begin
        req_fired = 1'b1;
        sent_req  = request_q.pop_front();
        cipher_expect_q.push_back(next_cipher_word(sent_req.plain, sent_req.last));
        words_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        if (cipher_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: cipher_word expected none, actual %h", $time, cipher_word_o);
        end else begin
          cipher_due = cipher_expect_q.pop_front();
          if (cipher_word_o !== cipher_due) begin
            mismatches++;
            $display("%0t: cipher_word expected %h, actual %h", $time, cipher_due,
                     cipher_word_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned i;
    int unsigned ph;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset key and nonce: message end on the first word, a full block and
    // the step into the next one, then a message end in mid-block
    push_word(32'h0000_0000, 1'b1);
    for (i = 0; i < 17; i++) begin
      case (i % 4)
        0: push_word(32'h0000_0000, 1'b0);
        1: push_word(32'hffff_ffff, 1'b0);
        2: push_word(32'h8000_0000, 1'b0);
        default: push_word(32'h0000_0001, 1'b0);
      endcase
    end
    push_word(32'h8000_0001, 1'b1);
    drain();

    // all-ones key and nonce, message left open for a mid-block rekey
    apply_setting(1);
    push_word(32'hffff_ffff, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h7fff_fffe, 1'b0);
    push_word(32'h5a5a_a5a5, 1'b0);
    push_word(32'hffff_ffff, 1'b0);
    drain();

    // random phases, the last one without idling
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_setting(ph % 4);
      calm = (ph == RANDOM_PHASES - 1);
      if (ph == 1) hold_request = 1'b1;
      queue_messages(PHASE_WORDS, ph % 3 == 1);
      drain();
    end

    $display("covered %0d words in %0d closed messages over %0d key/nonce settings,",
             words_in, message_count, settings_count + 1);
    $display("with %0d cipher words compared and the input held off on %0d cycles",
             words_out, full_cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
